// ===== rtl/core/amab_pkg.sv =====
// Package for the audio mix accumulate buffer.
// Holds the op codes, the fixed-point constants and the control state type.
// Depends on nothing.
package amab_pkg;

    // Op codes of the request channel
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_MIX   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Field widths
    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned PCM_W    = 16;
    localparam int unsigned MAG_W    = 23;
    localparam int unsigned SCALE_W  = 15;
    localparam int unsigned PROD_W   = MAG_W + SCALE_W;

    // 1.0 in Q2.22, and the PCM16 full scale
    localparam logic signed [ACC_W-1:0] UNITY     = 32'sd4194304;
    localparam logic signed [ACC_W-1:0] NEG_UNITY = -32'sd4194304;
    localparam logic [SCALE_W-1:0]      PCM_SCALE = 15'd32767;
    localparam logic [PROD_W-1:0]       ROUND_HALF = 38'd2097152;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_MUL,
        S_OUT
    } t_state;

endpackage

// ===== rtl/core/audio_mix_accumulate_buffer.sv =====
// Audio mix accumulate buffer: one synchronous accumulator memory and its sequencer.
// Depends on amab_pkg.
//
// A begin request is taken in the idle state alone; a mix request into the
// store passes through a memory read, then a saturating add and write back on
// the one memory port; a mix beyond the store and a read of an empty buffer
// also finish in the idle state. A read request passes through memory read,
// clamp and clear, 23x15 multiply and rounding into the output register, and
// waits while the output register stays full. The block takes one request at
// a time; the next is accepted while a result still waits in the output
// register. After reset a clearing pass writes zero to every entry, one per
// cycle, with the request channel stalled.
module audio_mix_accumulate_buffer
    import amab_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_op,
    input  logic [9:0]                  i_offset,
    input  logic [3:0]                  i_stride,
    input  logic signed [SAMPLE_W-1:0]  i_sample,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [SAMPLE_W-1:0]  o_clamped,
    output logic signed [PCM_W-1:0]     o_pcm,
    output logic                        o_last
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned PW = $clog2(DEPTH + 1);
    localparam int unsigned WW = PW + 1;
    localparam int unsigned OW = (PW > 10) ? PW : 10;

    // Accumulator store
    logic signed [ACC_W-1:0] mem [DEPTH];

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr, n_clr;
    logic [PW-1:0]           r_used, n_used;
    logic [PW-1:0]           r_wpos, n_wpos;
    logic [3:0]              r_wstep, n_wstep;
    logic [AW-1:0]           r_rd_pos, n_rd_pos;
    logic [AW-1:0]           r_addr, n_addr;
    logic [1:0]              r_op, n_op;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                    r_fin, n_fin;
    logic signed [ACC_W-1:0] r_rdata;
    logic signed [SAMPLE_W-1:0] r_clamp, n_clamp;
    logic [MAG_W-1:0]        r_mag, n_mag;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_clamped;
    logic signed [PCM_W-1:0] r_out_pcm, n_out_pcm;
    logic                    r_out_last;

    logic                    in_accept;
    logic                    out_load;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [ACC_W-1:0] mem_wdata;
    logic [OW-1:0]           off_ext;
    logic [WW-1:0]           step_sum;
    logic signed [ACC_W:0]   acc_sum;
    logic signed [ACC_W-1:0] acc_sat;
    logic [PROD_W-1:0]       rounded;
    logic [PCM_W-1:0]        pcm_mag;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Datapath helpers
    assign off_ext  = OW'(i_offset);
    assign step_sum = WW'(r_wpos) + WW'(r_wstep);
    assign acc_sum  = {r_rdata[ACC_W-1], r_rdata}
                    + {{(ACC_W + 1 - SAMPLE_W){r_sample[SAMPLE_W-1]}}, r_sample};
    assign rounded  = r_prod + ROUND_HALF;
    assign pcm_mag  = rounded[PROD_W-1:22];

    // Saturate the accumulation to 32 bits
    always_comb begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    // Next state, memory control and bookkeeping
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_used      = r_used;
        n_wpos      = r_wpos;
        n_wstep     = r_wstep;
        n_rd_pos    = r_rd_pos;
        n_addr      = r_addr;
        n_op        = r_op;
        n_fin       = r_fin;
        n_clamp     = r_clamp;
        n_mag       = r_mag;
        n_out_pcm   = r_out_pcm;
        n_out_valid = r_out_valid && i_out_stall;
        out_load    = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_wpos[AW-1:0];
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '0;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    case (i_op)
                        OP_BEGIN: begin
                            n_wpos  = (off_ext > OW'(DEPTH)) ? PW'(DEPTH) : PW'(off_ext);
                            n_wstep = i_stride;
                        end
                        OP_MIX: begin
                            // Drop writes beyond the store but still advance
                            if (r_wpos < PW'(DEPTH)) begin
                                rd_en   = 1'b1;
                                rd_addr = r_wpos[AW-1:0];
                                n_addr  = r_wpos[AW-1:0];
                                n_op    = OP_MIX;
                                n_state = S_RMW;
                                if (r_used < r_wpos + PW'(1)) begin
                                    n_used = r_wpos + PW'(1);
                                end
                            end
                            n_wpos = (step_sum > WW'(DEPTH)) ? PW'(DEPTH) : step_sum[PW-1:0];
                        end
                        OP_READ: begin
                            if (r_used != '0) begin
                                rd_en   = 1'b1;
                                rd_addr = r_rd_pos;
                                n_addr  = r_rd_pos;
                                n_op    = OP_READ;
                                n_state = S_RMW;
                                n_fin   = (PW'(r_rd_pos) + PW'(1) >= r_used);
                                if (PW'(r_rd_pos) + PW'(1) >= r_used) begin
                                    n_used   = '0;
                                    n_rd_pos = '0;
                                end else begin
                                    n_rd_pos = r_rd_pos + AW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RMW: begin
                mem_we = 1'b1;
                if (r_op == OP_MIX) begin
                    mem_wdata = acc_sat;
                    n_state   = S_IDLE;
                end else begin
                    // Clear the entry and clamp to plus or minus one
                    mem_wdata = '0;
                    if (r_rdata > UNITY) begin
                        n_clamp = SAMPLE_W'(UNITY);
                    end else if (r_rdata < NEG_UNITY) begin
                        n_clamp = SAMPLE_W'(NEG_UNITY);
                    end else begin
                        n_clamp = r_rdata[SAMPLE_W-1:0];
                    end
                    n_mag   = r_rdata[ACC_W-1] ? MAG_W'(-n_clamp) : MAG_W'(n_clamp);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_pcm   = r_clamp[SAMPLE_W-1] ? -$signed(pcm_mag) : $signed(pcm_mag);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Accumulator memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_wpos      <= '0;
            r_wstep     <= 4'd1;
            r_rd_pos    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_wpos      <= n_wpos;
            r_wstep     <= n_wstep;
            r_rd_pos    <= n_rd_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_op    <= n_op;
        r_fin   <= n_fin;
        r_clamp <= n_clamp;
        r_mag   <= n_mag;
        r_prod  <= PROD_W'(r_mag) * PROD_W'(PCM_SCALE);
        if (in_accept) begin
            r_sample <= i_sample;
        end
        r_out_pcm <= n_out_pcm;
        if (out_load) begin
            r_out_clamped <= r_clamp;
            r_out_last    <= r_fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_clamped   = r_out_clamped;
    assign o_pcm       = r_out_pcm;
    assign o_last      = r_out_last;

    // Checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !in_accept)
        else $error("request accepted during clearing pass");

    a_rd_pos_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used == '0) |-> (r_rd_pos == '0))
        else $error("read position not home while buffer empty");

    a_rd_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used != '0) |-> (PW'(r_rd_pos) < r_used))
        else $error("read position beyond used length");

    a_read_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW && r_op == OP_READ) |=> (r_state == S_MUL))
        else $error("read request left the result path");

    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output step");

endmodule
